### rtl/nns_pkg.sv
// nns_pkg: shared constants and types for the nearest-neighbor image scaler.
// No dependencies.
package nns_pkg;

  localparam int MAX_SOURCE_DIM_DEF = 64;
  localparam int MAX_TARGET_DIM_DEF = 1024;
  localparam int PIXEL_BITS_DEF     = 32;

  localparam int SRC_DIM_W = 7;
  localparam int TGT_DIM_W = 11;
  localparam int COORD_W   = 10;
  localparam int INDEX_W   = 12;
  localparam int COLOR_W   = 32;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 11;

  localparam logic [SRC_DIM_W-1:0] SRC_DIM_RST = SRC_DIM_W'(64);
  localparam logic [TGT_DIM_W-1:0] TGT_DIM_RST = TGT_DIM_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 4'd0,
    CFG_SOURCE_HEIGHT = 4'd1,
    CFG_TARGET_WIDTH  = 4'd2,
    CFG_TARGET_HEIGHT = 4'd3
  } cfg_reg_e;

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_REQUEST = 1'b1
  } kind_e;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [INDEX_W-1:0] lidx;
    logic [COLOR_W-1:0] color;
  } item_t;

endpackage

### rtl/nearest_neighbor_image_scaler_unit.sv
// nearest_neighbor_image_scaler_unit: top level, config registers, item pipeline.
// Depends on nns_pkg, nns_div, nns_store.
// Path: a request passes the scale-product registers, the divider stages, the store
// address register and the store read register before its result is on the ports.
// Throughput: one item per cycle; divisions are pipelined one quotient bit per stage.
// Reset: config registers go to 64, pipeline emptied; pixel store undefined until loaded.
// Results cannot be stalled; each is shown for one cycle with result_valid_o.
module nearest_neighbor_image_scaler_unit
  import nns_pkg::*;
#(
  parameter int MAX_SOURCE_DIM = MAX_SOURCE_DIM_DEF,
  parameter int MAX_TARGET_DIM = MAX_TARGET_DIM_DEF,
  parameter int PIXEL_BITS     = PIXEL_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 kind_i,
  input  logic [INDEX_W-1:0]   load_index_i,
  input  logic [COLOR_W-1:0]   load_color_i,
  input  logic [COORD_W-1:0]   request_x_i,
  input  logic [COORD_W-1:0]   request_y_i,
  output logic                 result_valid_o,
  output logic [COORD_W-1:0]   result_x_o,
  output logic [COORD_W-1:0]   result_y_o,
  output logic [COLOR_W-1:0]   result_color_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int SDIM_W = $clog2(MAX_SOURCE_DIM + 1);
  localparam int TDIM_W = $clog2(MAX_TARGET_DIM + 1);
  localparam int QUO_W  = (MAX_SOURCE_DIM > 1) ? $clog2(MAX_SOURCE_DIM) : 1;
  localparam int PROD_W = COORD_W + SDIM_W;
  localparam int DEPTH  = MAX_SOURCE_DIM * MAX_SOURCE_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = QUO_W + SDIM_W;
  localparam int PIPE   = QUO_W + 2;
  localparam int LAT    = PIPE + 1;

  // configuration
  logic [SRC_DIM_W-1:0] src_w_q, src_h_q;
  logic [TGT_DIM_W-1:0] tgt_w_q, tgt_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SRC_DIM_RST;
      src_h_q <= SRC_DIM_RST;
      tgt_w_q <= TGT_DIM_RST;
      tgt_h_q <= TGT_DIM_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SOURCE_WIDTH:  src_w_q <= SRC_DIM_W'(cfg_data_i);
        CFG_SOURCE_HEIGHT: src_h_q <= SRC_DIM_W'(cfg_data_i);
        CFG_TARGET_WIDTH:  tgt_w_q <= cfg_data_i;
        CFG_TARGET_HEIGHT: tgt_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [SDIM_W-1:0] eff_sw, eff_sh;
  logic [TDIM_W-1:0] eff_tw, eff_th;

  always_comb begin
    if (src_w_q == '0) eff_sw = SDIM_W'(1);
    else if (32'(src_w_q) > MAX_SOURCE_DIM) eff_sw = SDIM_W'(MAX_SOURCE_DIM);
    else eff_sw = SDIM_W'(src_w_q);
    if (src_h_q == '0) eff_sh = SDIM_W'(1);
    else if (32'(src_h_q) > MAX_SOURCE_DIM) eff_sh = SDIM_W'(MAX_SOURCE_DIM);
    else eff_sh = SDIM_W'(src_h_q);
    if (tgt_w_q == '0) eff_tw = TDIM_W'(1);
    else if (32'(tgt_w_q) > MAX_TARGET_DIM) eff_tw = TDIM_W'(MAX_TARGET_DIM);
    else eff_tw = TDIM_W'(tgt_w_q);
    if (tgt_h_q == '0) eff_th = TDIM_W'(1);
    else if (32'(tgt_h_q) > MAX_TARGET_DIM) eff_th = TDIM_W'(MAX_TARGET_DIM);
    else eff_th = TDIM_W'(tgt_h_q);
  end

  // accept
  logic  accept, in_ok;
  item_t in_item;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    if (kind_i == KIND_REQUEST) begin
      in_ok = (32'(request_x_i) < 32'(eff_tw)) && (32'(request_y_i) < 32'(eff_th));
    end else begin
      in_ok = (32'(load_index_i) < DEPTH);
    end
    in_item.kind  = kind_i;
    in_item.x     = request_x_i;
    in_item.y     = request_y_i;
    in_item.lidx  = load_index_i;
    in_item.color = load_color_i;
  end

  // item pipeline; loads and requests reach the store in order
  logic  vld_q [PIPE];
  item_t sb_q  [PIPE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= accept && in_ok;
      for (int i = 1; i < PIPE; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sb_q[0] <= in_item;
    for (int i = 1; i < PIPE; i++) begin
      sb_q[i] <= sb_q[i-1];
    end
  end

  // scale products, then divide by target size
  logic [PROD_W-1:0] prod_x_q, prod_y_q;
  logic [QUO_W-1:0]  col, row;

  always_ff @(posedge clk_i) begin
    prod_x_q <= PROD_W'(request_x_i) * PROD_W'(eff_sw);
    prod_y_q <= PROD_W'(request_y_i) * PROD_W'(eff_sh);
  end

  nns_div #(
    .NUM_W(PROD_W),
    .DEN_W(TDIM_W),
    .QUO_W(QUO_W)
  ) u_div_x (
    .clk_i(clk_i),
    .num_i(prod_x_q),
    .den_i(eff_tw),
    .quo_o(col)
  );

  nns_div #(
    .NUM_W(PROD_W),
    .DEN_W(TDIM_W),
    .QUO_W(QUO_W)
  ) u_div_y (
    .clk_i(clk_i),
    .num_i(prod_y_q),
    .den_i(eff_th),
    .quo_o(row)
  );

  // store address
  logic [ADDR_W-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (sb_q[QUO_W].kind == KIND_REQUEST) begin
      addr_q <= ADDR_W'(IDX_W'(row) * IDX_W'(eff_sw) + IDX_W'(col));
    end else begin
      addr_q <= ADDR_W'(sb_q[QUO_W].lidx);
    end
  end

  logic                  st_we, st_re;
  logic [PIXEL_BITS-1:0] st_rdata;

  assign st_we = vld_q[PIPE-1] && (sb_q[PIPE-1].kind == KIND_LOAD);
  assign st_re = vld_q[PIPE-1] && (sb_q[PIPE-1].kind == KIND_REQUEST);

  nns_store #(
    .DEPTH     (DEPTH),
    .ADDR_W    (ADDR_W),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .re_i   (st_re),
    .addr_i (addr_q),
    .wdata_i(PIXEL_BITS'(sb_q[PIPE-1].color)),
    .rdata_o(st_rdata)
  );

  // result
  logic               res_vld_q;
  logic [COORD_W-1:0] res_x_q, res_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= st_re;
    end
  end

  always_ff @(posedge clk_i) begin
    res_x_q <= sb_q[PIPE-1].x;
    res_y_q <= sb_q[PIPE-1].y;
  end

  assign result_valid_o = res_vld_q;
  assign result_x_o     = res_x_q;
  assign result_y_o     = res_y_q;
  assign result_color_o = COLOR_W'(st_rdata);

`ifndef SYNTHESIS
  a_result_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept && (kind_i == KIND_REQUEST), LAT))
    else $error("result without a matching request");

  a_result_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_x_o == $past(request_x_i, LAT)) &&
                       (result_y_o == $past(request_y_i, LAT)))
    else $error("result coordinate does not match its request");

  a_store_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_we && st_re))
    else $error("store read and write in the same cycle");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |=> !result_valid_o)
    else $error("load produced a result");
`endif

endmodule

### rtl/nns_div.sv
// nns_div: pipelined restoring divider, one quotient bit per stage.
// Assumes num < den * 2**QUO_W. Depends on nns_pkg.
module nns_div
  import nns_pkg::*;
#(
  parameter int NUM_W = COORD_W + SRC_DIM_W,
  parameter int DEN_W = TGT_DIM_W,
  parameter int QUO_W = 6
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] low_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   den_ext;
    logic             take;

    if (i == 0) begin : g_first
      assign rem_in = DEN_W'(num_i >> QUO_W);
      assign low_in = QUO_W'(num_i);
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign low_in = low_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    assign trial   = {rem_in, low_in[QUO_W-1]};
    assign den_ext = (DEN_W+1)'(den_i);
    assign take    = (trial >= den_ext);

    always_ff @(posedge clk_i) begin
      rem_q[i] <= take ? DEN_W'(trial - den_ext) : DEN_W'(trial);
      low_q[i] <= low_in << 1;
      quo_q[i] <= (quo_in << 1) | QUO_W'(take);
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

### rtl/nns_store.sv
// nns_store: single-port source pixel memory, registered read data.
// Depends on nns_pkg.
module nns_store
  import nns_pkg::*;
#(
  parameter int DEPTH      = MAX_SOURCE_DIM_DEF * MAX_SOURCE_DIM_DEF,
  parameter int ADDR_W     = 12,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic                  re_i,
  input  logic [ADDR_W-1:0]     addr_i,
  input  logic [PIXEL_BITS-1:0] wdata_i,
  output logic [PIXEL_BITS-1:0] rdata_o
);

  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [PIXEL_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
